// ===== sv/qoi_pkg.sv =====
// Shared types, op codes and the color hash for the QOI pixel encoder.
// No dependencies; every module of the encoder imports this package.
`timescale 1ns / 1ps

package qoi_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
  localparam int MAX_BYTES     = 6;
  localparam int COUNT_BITS    = $clog2(MAX_BYTES + 1);

  localparam logic [5:0] MAX_RUN = 6'd62;

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;
  localparam logic [7:0] OP_RGBA  = 8'hFF;

  localparam logic [31:0] RESET_PIXEL = 32'h0000_00FF;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       image_end;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] chunk_byte;
    logic       last_of_pixel;
  } chunk_out_t;

  // Bytes of one pixel, bytes[0] goes out first.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [COUNT_BITS-1:0]     count;
  } chunk_group_t;

  typedef struct packed {
    chunk_group_t grp;
    logic         tbl_write;
    logic [5:0]   run_next;
    logic         pixel_repeat;
  } coder_result_t;

  function automatic logic [31:0] pack_pixel(input pixel_in_t p);
    return {p.red_in, p.green_in, p.blue_in, p.alpha_in};
  endfunction

  // (3r + 5g + 7b + 11a) mod 64, only the low six bits matter.
  function automatic logic [SLOT_BITS-1:0] qoi_hash(input pixel_in_t p);
    logic [SLOT_BITS-1:0] r, g, b, a;
    r = p.red_in[SLOT_BITS-1:0];
    g = p.green_in[SLOT_BITS-1:0];
    b = p.blue_in[SLOT_BITS-1:0];
    a = p.alpha_in[SLOT_BITS-1:0];
    return SLOT_BITS'(r * SLOT_BITS'(3) + g * SLOT_BITS'(5)
                      + b * SLOT_BITS'(7) + a * SLOT_BITS'(11));
  endfunction

endpackage

// ===== sv/qoi_color_table.sv =====
// 64-entry color table: RAM with registered read, per-entry valid flops
// and a one-deep write bypass for a read issued on the same edge. Uses qoi_pkg.
`timescale 1ns / 1ps

module qoi_color_table
  import qoi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [SLOT_BITS-1:0] rd_addr,
  input  logic                 wr_en,
  input  logic [SLOT_BITS-1:0] wr_addr,
  input  logic [31:0]          wr_data,
  input  logic                 clear,
  output logic [SLOT_BITS-1:0] entry_slot,
  output logic [31:0]          entry
);

  logic [31:0]              mem [TABLE_ENTRIES];
  logic [31:0]              mem_q;
  logic [TABLE_ENTRIES-1:0] valid;
  logic                     byp_hit;
  logic [31:0]              byp_data;
  logic [SLOT_BITS-1:0]     slot;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      slot     <= rd_addr;
      byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      byp_hit <= 1'b0;
    end else begin
      if (clear) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      // read and write of the same slot on one edge: RAM returns old data
      if (rd_en) begin
        byp_hit <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  assign entry_slot = slot;
  assign entry      = !valid[slot] ? 32'h0 : (byp_hit ? byp_data : mem_q);

endmodule

// ===== sv/qoi_chunk_coder.sv =====
// Chunk selection for one pixel: run handling, INDEX/DIFF/LUMA/RGB/RGBA,
// byte assembly and next run count. Purely combinational. Uses qoi_pkg.
`timescale 1ns / 1ps

module qoi_chunk_coder
  import qoi_pkg::*;
(
  input  pixel_in_t            pix,
  input  logic [31:0]          prev,
  input  logic [5:0]           run,
  input  logic [SLOT_BITS-1:0] slot,
  input  logic [31:0]          entry,
  output coder_result_t        res
);

  logic [31:0]       px;
  logic              repeat_px;
  logic [5:0]        run_inc;
  logic              run_emit;
  logic              flush;
  logic              hit;
  logic signed [7:0] vr, vg, vb;
  logic signed [8:0] vgr, vgb;
  logic              diff_ok, luma_ok;
  logic [4:0][7:0]   cb;
  logic [2:0]        clen;

  assign px        = pack_pixel(pix);
  assign repeat_px = (px == prev);
  assign run_inc   = run + 6'd1;
  assign run_emit  = (run_inc >= MAX_RUN) || pix.image_end;
  assign flush     = !repeat_px && (run != 6'd0);
  assign hit       = (entry == px);

  assign vr  = signed'(pix.red_in - prev[31:24]);
  assign vg  = signed'(pix.green_in - prev[23:16]);
  assign vb  = signed'(pix.blue_in - prev[15:8]);
  assign vgr = {vr[7], vr} - {vg[7], vg};
  assign vgb = {vb[7], vb} - {vg[7], vg};

  assign diff_ok = (vr >= -8'sd2) && (vr <= 8'sd1) && (vg >= -8'sd2) && (vg <= 8'sd1)
                && (vb >= -8'sd2) && (vb <= 8'sd1);
  assign luma_ok = (vgr >= -9'sd8) && (vgr <= 9'sd7) && (vgb >= -9'sd8) && (vgb <= 9'sd7)
                && (vg >= -8'sd32) && (vg <= 8'sd31);

  // color chunk, without any run flush in front
  always_comb begin
    cb   = '0;
    clen = 3'd0;
    if (hit) begin
      cb[0] = OP_INDEX | {2'b00, slot};
      clen  = 3'd1;
    end else if (pix.alpha_in != prev[7:0]) begin
      cb    = {pix.alpha_in, pix.blue_in, pix.green_in, pix.red_in, OP_RGBA};
      clen  = 3'd5;
    end else if (diff_ok) begin
      cb[0] = OP_DIFF | {2'b00, vr[1:0] + 2'd2, vg[1:0] + 2'd2, vb[1:0] + 2'd2};
      clen  = 3'd1;
    end else if (luma_ok) begin
      cb[0] = OP_LUMA | {2'b00, vg[5:0] + 6'd32};
      cb[1] = {vgr[3:0] + 4'd8, vgb[3:0] + 4'd8};
      clen  = 3'd2;
    end else begin
      cb[3:0] = {pix.blue_in, pix.green_in, pix.red_in, OP_RGB};
      clen    = 3'd4;
    end
  end

  always_comb begin
    res              = '0;
    res.pixel_repeat = repeat_px;
    if (repeat_px) begin
      res.grp.bytes[0] = OP_RUN | {2'b00, run};
      res.grp.count    = run_emit ? COUNT_BITS'(1) : COUNT_BITS'(0);
      res.run_next     = run_emit ? 6'd0 : run_inc;
    end else begin
      res.tbl_write = !hit && !pix.image_end;
      res.run_next  = 6'd0;
      if (flush) begin
        res.grp.bytes[0]   = OP_RUN | {2'b00, run - 6'd1};
        res.grp.bytes[5:1] = cb;
        res.grp.count      = COUNT_BITS'(clen) + COUNT_BITS'(1);
      end else begin
        res.grp.bytes[4:0] = cb;
        res.grp.count      = COUNT_BITS'(clen);
      end
    end
    if (pix.image_end) begin
      res.run_next = 6'd0;
    end
  end

endmodule

// ===== sv/qoi_byte_serializer.sv =====
// Output stage: holds the bytes of one pixel and sends them one per
// transaction, flagging the final byte. Uses qoi_pkg.
`timescale 1ns / 1ps

module qoi_byte_serializer
  import qoi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  chunk_group_t grp,
  output logic         free,
  output logic         chunk_valid,
  input  logic         chunk_ready,
  output chunk_out_t   chunk
);

  logic [MAX_BYTES-1:0][7:0] bytes;
  logic [COUNT_BITS-1:0]     cnt;
  logic                      send;

  assign chunk_valid         = (cnt != '0);
  assign send                = chunk_valid && chunk_ready;
  assign free                = (cnt == '0) || ((cnt == COUNT_BITS'(1)) && chunk_ready);
  assign chunk.chunk_byte    = bytes[0];
  assign chunk.last_of_pixel = (cnt == COUNT_BITS'(1));

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= grp.bytes;
    end else if (send) begin
      bytes <= {8'h00, bytes[MAX_BYTES-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= grp.count;
    end else if (send) begin
      cnt <= cnt - COUNT_BITS'(1);
    end
  end

endmodule

// ===== sv/qoi_pixel_encoder.sv =====
// QOI pixel encoder top level: input register, color table, chunk coder
// and byte serializer. Uses qoi_pkg and the qoi_* submodules.
`timescale 1ns / 1ps

// Usage
//   pixel channel: one RGBA pixel per transaction in raster order, with
//   image_end set on the last pixel of the image.
//   chunk channel: the QOI chunk bytes, one per transaction; last_of_pixel
//   marks the final byte caused by a pixel. Header and end marker come from
//   software.
// Path: the first byte of a pixel passes the input register, whose table
//   read is registered with it, then the output register, from which it is
//   offered; it waits in the input register while the output register is busy.
// Throughput: one pixel per cycle while each pixel makes at most one byte
//   and the receiver takes every byte; a pixel of more bytes (up to six) holds
//   the next pixel in the input register until the byte-wide output register
//   has sent them. Pixels that only extend a run make no bytes and do not wait.
// Reset clears the previous pixel to opaque black, the run count and the
//   color table valid bits; pixel_ready is low during reset and the block is
//   ready on the cycle after reset. The same state returns after image_end.
// A stalled receiver holds the output register; one more pixel waits in
//   the input register, then pixel_ready drops.

module qoi_pixel_encoder
  import qoi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  output logic       pixel_ready,
  input  pixel_in_t  pixel,
  output logic       chunk_valid,
  input  logic       chunk_ready,
  output chunk_out_t chunk
);

  logic                 a_valid;
  pixel_in_t            a_pix;
  logic [31:0]          prev;
  logic [5:0]           run;
  logic                 accept;
  logic                 a_move;
  logic                 ser_free;
  logic [SLOT_BITS-1:0] entry_slot;
  logic [31:0]          entry;
  coder_result_t        res;

  assign accept      = pixel_valid && pixel_ready;
  assign a_move      = a_valid && ((res.grp.count == '0) || ser_free);
  assign pixel_ready = !rst && (!a_valid || a_move);

  qoi_color_table u_table (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (accept),
    .rd_addr    (qoi_hash(pixel)),
    .wr_en      (a_move && res.tbl_write),
    .wr_addr    (entry_slot),
    .wr_data    (pack_pixel(a_pix)),
    .clear      (a_move && a_pix.image_end),
    .entry_slot (entry_slot),
    .entry      (entry)
  );

  qoi_chunk_coder u_coder (
    .pix   (a_pix),
    .prev  (prev),
    .run   (run),
    .slot  (entry_slot),
    .entry (entry),
    .res   (res)
  );

  qoi_byte_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .load        (a_move && (res.grp.count != '0)),
    .grp         (res.grp),
    .free        (ser_free),
    .chunk_valid (chunk_valid),
    .chunk_ready (chunk_ready),
    .chunk       (chunk)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      prev    <= RESET_PIXEL;
      run     <= 6'd0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        prev <= a_pix.image_end ? RESET_PIXEL : pack_pixel(a_pix);
        run  <= res.run_next;
      end
    end
  end

  a_run_below_max: assert property (@(posedge clk) disable iff (rst) run < MAX_RUN)
    else $error("run count reached its limit without a flush");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (a_move && a_pix.image_end) |=> (run == 6'd0 && prev == RESET_PIXEL))
    else $error("state not restored after last pixel");

  a_silent_is_repeat: assert property (@(posedge clk) disable iff (rst)
    (a_move && res.grp.count == '0) |-> (res.pixel_repeat && !a_pix.image_end))
    else $error("pixel left without bytes outside an open run");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> pixel_ready)
    else $error("input stalled with empty input register");

endmodule
